/* hw/rtl/rfc_pkg.sv */
// Shared types, constants and helpers for the rectangle fill chunk generator.
package rfc_pkg;

  localparam int unsigned CoordW    = 10;
  localparam int unsigned WinW      = 9;
  localparam int unsigned TotalW    = 20;
  localparam int unsigned CountW    = 14;
  localparam int unsigned DivCntW   = 4;
  localparam int unsigned ChunkIdxW = 5;
  localparam logic [ChunkIdxW-1:0] LastChunkIdx = 5'd31;

  typedef struct packed {
    logic [23:0] color_rgb888;
    logic [9:0]  left_x;
    logic [9:0]  rect_width;
    logic [9:0]  top_y;
    logic [9:0]  rect_height;
  } fill_req_t;

  typedef struct packed {
    logic [8:0]  window_x_first;
    logic [8:0]  window_x_final;
    logic [8:0]  window_y_first;
    logic [8:0]  window_y_final;
    logic [13:0] pixel_count;
    logic [15:0] color_rgb565;
    logic        last_chunk;
  } chunk_t;

  // Classified request: geometry, pixel total and the chunk stride split
  // into whole rows (quot) and leftover columns (rmd).
  typedef struct packed {
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] h;
    logic [TotalW-1:0] total;
    logic [CountW-1:0] quot;
    logic [CoordW-1:0] rmd;
    logic [15:0]       rgb;
  } fill_desc_t;

  typedef enum logic [1:0] {
    FrIdle,
    FrDivide,
    FrPush
  } front_state_e;

  function automatic logic [15:0] pack_rgb565(logic [23:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

/* hw/rtl/rfc_front.sv */
// Front end: takes requests, drops off-screen or empty ones, works out the chunk stride.
module rfc_front #(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 320,
  parameter int unsigned CHUNK_PIXELS  = 5120
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rfc_pkg::fill_req_t  in_item_i,
  output logic                push_valid_o,
  input  logic                push_full_i,
  output rfc_pkg::fill_desc_t push_desc_o
);
  import rfc_pkg::*;

  localparam logic [CoordW:0]   ScrW   = (CoordW+1)'(SCREEN_WIDTH);
  localparam logic [CoordW:0]   ScrH   = (CoordW+1)'(SCREEN_HEIGHT);
  localparam logic [CountW-1:0] ChunkL = CountW'(CHUNK_PIXELS);
  localparam logic [DivCntW-1:0] DivTop = DivCntW'(CountW - 1);

  front_state_e        state_q, state_d;
  fill_desc_t          desc_q, desc_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [CoordW:0]     trial;
  logic                fits;

  assign fits = ({1'b0, in_item_i.left_x} + {1'b0, in_item_i.rect_width} <= ScrW) &&
                ({1'b0, in_item_i.top_y} + {1'b0, in_item_i.rect_height} <= ScrH) &&
                (in_item_i.rect_width != '0) && (in_item_i.rect_height != '0);

  // restoring division step, one quotient bit per cycle
  assign trial = {desc_q.rmd, ChunkL[cnt_q]};

  always_comb begin
    state_d      = state_q;
    desc_d       = desc_q;
    cnt_d        = cnt_q;
    push_valid_o = 1'b0;
    unique case (state_q)
      FrIdle: begin
        if (in_valid_i && fits) begin
          desc_d.x0    = in_item_i.left_x;
          desc_d.w     = in_item_i.rect_width;
          desc_d.y0    = in_item_i.top_y;
          desc_d.h     = in_item_i.rect_height;
          desc_d.total = TotalW'(in_item_i.rect_width) * TotalW'(in_item_i.rect_height);
          desc_d.quot  = '0;
          desc_d.rmd   = '0;
          desc_d.rgb   = pack_rgb565(in_item_i.color_rgb888);
          cnt_d        = DivTop;
          state_d      = FrDivide;
        end
      end
      FrDivide: begin
        if (trial >= {1'b0, desc_q.w}) begin
          desc_d.rmd  = CoordW'(trial - {1'b0, desc_q.w});
          desc_d.quot = {desc_q.quot[CountW-2:0], 1'b1};
        end else begin
          desc_d.rmd  = CoordW'(trial);
          desc_d.quot = {desc_q.quot[CountW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = FrPush;
        end
      end
      FrPush: begin
        push_valid_o = 1'b1;
        if (!push_full_i) begin
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  assign in_stall_o  = (state_q != FrIdle);
  assign push_desc_o = desc_q;

endmodule

/* hw/rtl/rfc_queue.sv */
// Two-entry queue of classified requests between front and back.
module rfc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rfc_pkg::fill_desc_t push_desc_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output rfc_pkg::fill_desc_t head_desc_o
);
  import rfc_pkg::*;

  fill_desc_t  mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  count_q;
  logic        do_push, do_pop;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_desc_o  = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_desc_i;
  end

endmodule

/* hw/rtl/rfc_back.sv */
// Back end: walks one classified request chunk by chunk into the output register.
module rfc_back #(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 320,
  parameter int unsigned CHUNK_PIXELS  = 5120
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  rfc_pkg::fill_desc_t head_desc_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rfc_pkg::chunk_t     out_item_o
);
  import rfc_pkg::*;

  localparam logic [CoordW:0]   ScrWMax = (CoordW+1)'(SCREEN_WIDTH - 1);
  localparam logic [CoordW:0]   ScrHMax = (CoordW+1)'(SCREEN_HEIGHT - 1);
  localparam logic [CountW-1:0] ChunkL  = CountW'(CHUNK_PIXELS);

  logic [CoordW-1:0]    off_q, off_d, row_q, row_d;
  logic [TotalW-1:0]    sent_q, sent_d;
  logic [ChunkIdxW-1:0] n_q, n_d;
  logic                 out_valid_q;
  chunk_t               out_q;

  logic                 emit, last;
  logic [CoordW-1:0]    x1, y1;
  logic [CoordW:0]      x2, y2;
  logic [TotalW-1:0]    remaining;
  logic [CountW-1:0]    npix;

  assign emit      = head_valid_i && (!out_valid_q || !out_stall_i);
  assign x1        = head_desc_i.x0 + off_q;
  assign y1        = head_desc_i.y0 + row_q;
  assign remaining = head_desc_i.total - sent_q;

  always_comb begin
    x2 = {1'b0, x1} + {1'b0, head_desc_i.w} - 1'b1;
    if (x2 > ScrWMax) x2 = ScrWMax;
    y2 = {1'b0, y1} + {1'b0, head_desc_i.h} - 1'b1;
    if (y2 > ScrHMax) y2 = ScrHMax;
  end

  // mid-row start finishes the row; row start takes the rest or one full chunk
  always_comb begin
    off_d = off_q;
    row_d = row_q;
    priority if (off_q != '0) begin
      npix  = CountW'(head_desc_i.w - off_q);
      off_d = '0;
      row_d = row_q + 1'b1;
    end else if (remaining <= TotalW'(ChunkL)) begin
      npix  = CountW'(remaining);
    end else begin
      npix  = ChunkL;
      off_d = head_desc_i.rmd;
      row_d = CoordW'(CountW'(row_q) + head_desc_i.quot);
    end
    last   = (remaining == TotalW'(npix)) || (n_q == LastChunkIdx);
    sent_d = sent_q + TotalW'(npix);
    n_d    = n_q + 1'b1;
    if (last) begin
      off_d  = '0;
      row_d  = '0;
      sent_d = '0;
      n_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      row_q       <= '0;
      sent_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        off_q  <= off_d;
        row_q  <= row_d;
        sent_q <= sent_d;
        n_q    <= n_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.window_x_first <= WinW'(x1);
      out_q.window_x_final <= WinW'(x2);
      out_q.window_y_first <= WinW'(y1);
      out_q.window_y_final <= WinW'(y2);
      out_q.pixel_count    <= npix;
      out_q.color_rgb565   <= head_desc_i.rgb;
      out_q.last_chunk     <= last;
    end
  end

  assign pop_o       = emit && last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hw/rtl/rect_fill_chunk_generator.sv */
// Rectangle fill chunk generator top level: front end, request queue, chunk walker.
// The front end takes one request at a time and stalls its input while it divides for
//   the stride; the back end emits one chunk per cycle when the output is not stalled,
//   and a request gives at most 32 chunks.
// Rejected (off-screen or empty) requests produce nothing.
// Reset: asynchronous, active low; clears queue, walker position and output valid.
module rect_fill_chunk_generator #(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 320,
  parameter int unsigned CHUNK_PIXELS  = 5120
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rfc_pkg::fill_req_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rfc_pkg::chunk_t    out_item_o
);
  import rfc_pkg::*;

  // front -> queue
  logic       push_valid, q_full;
  fill_desc_t push_desc;
  // queue -> back
  logic       head_valid, pop;
  fill_desc_t head_desc;

  // Front: range check, pixel total, RGB565 packing, and CHUNK_PIXELS / width
  // by a bit-serial divider. The quotient and remainder give the row and
  // column step of every full chunk that starts at a row boundary.
  rfc_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .CHUNK_PIXELS (CHUNK_PIXELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_valid_o(push_valid),
    .push_full_i (q_full),
    .push_desc_o (push_desc)
  );

  // Two requests fit here, counting the one the back end is draining.
  rfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_desc_o (head_desc)
  );

  // Back: keeps column offset, row and pixels sent for the head request;
  // pops it on the final chunk (end of pixels or the 32nd chunk).
  rfc_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .CHUNK_PIXELS (CHUNK_PIXELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_desc_i (head_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
